@@ sv/ais_pkg.sv @@
// ---------------------------------------------------------------------------
// ais_pkg
// Shared types and constants for the ascending integer sorter.
// ---------------------------------------------------------------------------
package ais_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    typedef struct packed {
        logic store;      // write the accepted beat into the store
        logic sort_init;  // load the pass limit from the fill count
        logic pass_init;  // read entry zero, set the compare index to one
        logic pass_load;  // capture entry zero as carry, read next entry
        logic pass_step;  // compare carry with read data, write back
        logic pass_end;   // write carry at the pass limit, shrink limit
        logic emit_init;  // clear the emit index
        logic emit_read;  // read the entry at the emit index
        logic emit_load;  // fill the output register
        logic emit_next;  // advance the emit index
        logic set_clear;  // drop fill count and overflow flag
    } ais_cmd_t;

    typedef struct packed {
        logic limit_zero;
        logic idx_at_limit;
        logic out_done;
        logic out_last;
    } ais_status_t;

endpackage

@@ sv/ais_datapath.sv @@
// ---------------------------------------------------------------------------
// ais_datapath
// Element store, sort carry register, counters and output register.
// ---------------------------------------------------------------------------
module ais_datapath
    import ais_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ais_cmd_t                   cmd,
    output ais_status_t                status,
    input  logic signed [VALUE_W-1:0]  value,
    output logic signed [VALUE_W-1:0]  sorted_value,
    output logic        [RANK_W-1:0]   rank,
    output logic                       last_out,
    output logic                       overflow,
    output logic                       out_valid,
    input  logic                       out_ready
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [VALUE_W-1:0] mem [MAX_ELEMENTS];

    logic [CW-1:0]      fill_reg,   fill_next;
    logic               dropped_reg, dropped_next;
    logic [IW-1:0]      limit_reg,  limit_next;
    logic [IW-1:0]      idx_reg,    idx_next;
    logic [VALUE_W-1:0] carry_reg,  carry_next;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    logic               we;
    logic [IW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [IW-1:0]      raddr;
    logic               swap;
    logic               room;
    logic               out_done;

    assign room     = (fill_reg < CW'(MAX_ELEMENTS));
    assign swap     = $signed(carry_reg) > $signed(rd_data_reg);
    assign out_done = out_valid_reg && out_ready;

    always_comb
    begin
        we    = 1'b0;
        waddr = fill_reg[IW-1:0];
        wdata = value;
        if (cmd.store)
        begin
            we = room;
        end
        else if (cmd.pass_step)
        begin
            we    = 1'b1;
            waddr = idx_reg - 1'b1;
            wdata = swap ? rd_data_reg : carry_reg;
        end
        else if (cmd.pass_end)
        begin
            we    = 1'b1;
            waddr = limit_reg;
            wdata = carry_reg;
        end
    end

    always_comb
    begin
        raddr = idx_reg;
        if (cmd.pass_init)
        begin
            raddr = '0;
        end
        else if (cmd.pass_step)
        begin
            raddr = idx_reg + 1'b1;
        end
        else if (cmd.emit_read)
        begin
            raddr = idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        limit_next     = limit_reg;
        idx_next       = idx_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg;
        if (cmd.store)
        begin
            if (room)
            begin
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        if (cmd.sort_init)
        begin
            limit_next = IW'(fill_reg - 1'b1);
        end
        if (cmd.pass_init)
        begin
            idx_next = IW'(1);
        end
        if (cmd.pass_load)
        begin
            carry_next = rd_data_reg;
        end
        if (cmd.pass_step)
        begin
            idx_next = idx_reg + 1'b1;
            if (!swap)
            begin
                carry_next = rd_data_reg;
            end
        end
        if (cmd.pass_end)
        begin
            limit_next = limit_reg - 1'b1;
        end
        if (cmd.emit_init)
        begin
            idx_next = '0;
        end
        if (cmd.emit_next)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_done)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.set_clear)
        begin
            fill_next    = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
        idx_reg   <= idx_next;
        carry_reg <= carry_next;
        if (cmd.emit_load)
        begin
            out_value_reg <= rd_data_reg;
            out_rank_reg  <= RANK_W'(idx_reg);
            out_last_reg  <= (CW'(idx_reg) + 1'b1 == fill_reg);
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign status.limit_zero   = (limit_reg == '0);
    assign status.idx_at_limit = (idx_reg == limit_reg);
    assign status.out_done     = out_done;
    assign status.out_last     = out_last_reg;

    assign sorted_value = out_value_reg;
    assign rank         = out_rank_reg;
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;
    assign out_valid    = out_valid_reg;

endmodule

@@ sv/ais_ctrl.sv @@
// ---------------------------------------------------------------------------
// ais_ctrl
// Sequencer for load, bubble passes and emit of the sorter.
// ---------------------------------------------------------------------------
module ais_ctrl
    import ais_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        end_of_set,
    output logic        in_ready,
    input  ais_status_t status,
    output ais_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_LOAD      = 10'b00_0000_0001,
        ST_INIT      = 10'b00_0000_0010,
        ST_CHECK     = 10'b00_0000_0100,
        ST_FIRST     = 10'b00_0000_1000,
        ST_PASS      = 10'b00_0001_0000,
        ST_PASS_END  = 10'b00_0010_0000,
        ST_EMIT_RD   = 10'b00_0100_0000,
        ST_EMIT_LD   = 10'b00_1000_0000,
        ST_EMIT_WAIT = 10'b01_0000_0000,
        ST_SPARE     = 10'b10_0000_0000
    } ais_state_t;

    ais_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (end_of_set)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.limit_zero)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                cmd.pass_load = 1'b1;
                state_next    = ST_PASS;
            end
            ST_PASS:
            begin
                cmd.pass_step = 1'b1;
                if (status.idx_at_limit)
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END:
            begin
                cmd.pass_end = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (status.out_done)
                begin
                    if (status.out_last)
                    begin
                        cmd.set_clear = 1'b1;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/ascending_integer_sorter.sv @@
// ---------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a set of signed integers, bubble sorts it in place, streams it out.
// ---------------------------------------------------------------------------
// Beats load one per cycle into a single-port-write, registered-read store of
// MAX_ELEMENTS entries; beats beyond the depth are dropped and flagged on
// overflow. The beat with end_of_set starts the sort, during which in_ready is
// low. Each bubble pass streams the store through one compare-and-swap unit
// holding the running maximum, one entry per cycle. Results then leave one
// beat at a time (read, register, handshake), each held until out_ready takes
// it; rank counts from zero and last_out marks the final beat, after which the
// block takes a new set.
// ---------------------------------------------------------------------------
module ascending_integer_sorter
    import ais_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       end_of_set,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  sorted_value,
    output logic        [RANK_W-1:0]   rank,
    output logic                       last_out,
    output logic                       overflow
);

    ais_cmd_t    cmd;
    ais_status_t status;

    ais_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .end_of_set (end_of_set),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ais_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .sorted_value (sorted_value),
        .rank         (rank),
        .last_out     (last_out),
        .overflow     (overflow),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_set) |=> !in_ready)
        else $error("input still open after end of set");

    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_out) |=> (in_ready && !out_valid))
        else $error("block not back to load after final beat");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rank <= RANK_W'(MAX_ELEMENTS - 1)))
        else $error("rank beyond store depth");

endmodule

@@ verif/tb_ascending_integer_sorter.sv @@
// ---------------------------------------------------------------------------
// tb_ascending_integer_sorter
// Self-checking bench: streams integer sets in, checks every sorted beat out.
// ---------------------------------------------------------------------------
// A scoreboard class gathers each accepted element, and on the closing beat
// sorts its own copy of the set (signed, ascending, capped at the store depth)
// into a queue of expected beats. Every output beat is checked against the
// oldest one: value, rank, last flag and overflow. Directed sets cover single
// elements, the signed extremes, duplicates and presorted order; random sets
// then cover a full store and two short sets with no gaps, then an overflowing
// store and more short sets with random gaps on both handshakes.
// ---------------------------------------------------------------------------
module tb_ascending_integer_sorter;
    import ais_pkg::*;

    localparam int DEPTH      = 64;
    localparam int LIMIT      = 200000;
    localparam int IDLE_PCT   = 28;
    localparam int DIR_COUNT  = 21;
    localparam int RAND_ITEMS = 145;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic        [RANK_W-1:0]  rank;
        logic                      last;
        logic                      ovf;
    } sorted_beat_t;

    class sorted_run_board;
        logic signed [VALUE_W-1:0] gathered[$];
        bit                        dropped;
        sorted_beat_t              sorted_due[$];
        int                        errors;

        function new();
            dropped = 0;
            errors  = 0;
        endfunction

        function void note_element(logic signed [VALUE_W-1:0] v, logic eos);
            logic signed [VALUE_W-1:0] tmp;
            sorted_beat_t              beat;
            int                        n;
            if (gathered.size() < DEPTH)
                gathered.push_back(v);
            else
                dropped = 1;
            if (!eos)
                return;
            n = gathered.size();
            for (int pass = 0; pass < n - 1; pass++)
            begin
                for (int k = 0; k < n - 1 - pass; k++)
                begin
                    if (gathered[k] > gathered[k+1])
                    begin
                        tmp           = gathered[k];
                        gathered[k]   = gathered[k+1];
                        gathered[k+1] = tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++)
            begin
                beat.value = gathered[k];
                beat.rank  = RANK_W'(k);
                beat.last  = (k == n - 1);
                beat.ovf   = dropped;
                sorted_due.push_back(beat);
            end
            gathered.delete();
            dropped = 0;
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] v, logic [RANK_W-1:0] r,
                                   logic l, logic o);
            sorted_beat_t exp_beat;
            if (sorted_due.size() == 0)
            begin
                $error("unexpected result beat: sorted_value %0d rank %0d", v, r);
                errors++;
                return;
            end
            exp_beat = sorted_due.pop_front();
            if (v !== exp_beat.value)
            begin
                $error("sorted_value: expected %0d, actual %0d", exp_beat.value, v);
                errors++;
            end
            if (r !== exp_beat.rank)
            begin
                $error("rank: expected %0d, actual %0d", exp_beat.rank, r);
                errors++;
            end
            if (l !== exp_beat.last)
            begin
                $error("last_out: expected %0b, actual %0b", exp_beat.last, l);
                errors++;
            end
            if (o !== exp_beat.ovf)
            begin
                $error("overflow: expected %0b, actual %0b", exp_beat.ovf, o);
                errors++;
            end
        endfunction

        function int pending();
            return sorted_due.size();
        endfunction
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value      = '0;
    logic                      end_of_set = 1'b0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic signed [VALUE_W-1:0] sorted_value;
    logic        [RANK_W-1:0]  rank;
    logic                      last_out;
    logic                      overflow;

    sorted_run_board board;
    bit              stalls_on = 1'b1;
    int              cycles    = 0;
    int              rand_sent = 0;
    logic [VALUE_W-1:0] dir_vals[DIR_COUNT];
    bit                 dir_last[DIR_COUNT];

    ascending_integer_sorter #(
        .MAX_ELEMENTS (DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .end_of_set   (end_of_set),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .rank         (rank),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= stalls_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(sorted_value, rank, last_out, overflow);
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2, 3:    v = VALUE_W'($urandom_range(16)) - 32'd8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_element(logic [VALUE_W-1:0] v, logic eos);
        while (stalls_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        value      <= v;
        end_of_set <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_element(value, end_of_set);
        @(negedge clk);
    endtask

    task automatic push_random_set(int n);
        for (int i = 0; i < n; i++)
            push_element(pick_value(), i == n - 1);
        rand_sent += n;
    endtask

    initial
    begin
        board = new();
        dir_vals = '{32'h8000_0000,
                     32'h7fff_ffff,
                     32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'h8000_0000, 32'd1,
                     32'd5, 32'hffff_fffd, 32'd5, 32'hffff_fffd, 32'd5,
                     32'hffff_fffe, 32'hffff_ffff, 32'd0, 32'd1, 32'd2,
                     32'd3, 32'd2, 32'd1, 32'd0};
        dir_last = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                     1'b1};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_COUNT; i++)
            push_element(dir_vals[i], dir_last[i]);

        // full store and two short sets with no gaps, then a set whose tail and closing beat drop
        stalls_on = 1'b0;
        push_random_set(DEPTH);
        push_random_set(3);
        push_random_set(1);
        stalls_on = 1'b1;
        push_random_set(DEPTH + 2);
        while (rand_sent < RAND_ITEMS)
            push_random_set($urandom_range(1, 8));
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/ais_pkg.sv
sv/ais_datapath.sv
sv/ais_ctrl.sv
sv/ascending_integer_sorter.sv
verif/tb_ascending_integer_sorter.sv
